[src/drcr_pkg.sv]
// shared constants for the rectangle clip and rotate command block
`default_nettype none
package drcr_pkg;

    // command opcodes
    localparam logic OP_FILL  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // output word kinds
    localparam logic KIND_REG = 1'b0;
    localparam logic KIND_RUN = 1'b1;

    // controller register indexes
    localparam logic [7:0] REG_RAM_X      = 8'h20;
    localparam logic [7:0] REG_RAM_Y      = 8'h21;
    localparam logic [7:0] REG_GRAM       = 8'h22;
    localparam logic [7:0] REG_HWIN_END   = 8'h36;
    localparam logic [7:0] REG_HWIN_START = 8'h37;
    localparam logic [7:0] REG_VWIN_END   = 8'h38;
    localparam logic [7:0] REG_VWIN_START = 8'h39;

    // number of writes that set up one window
    localparam int WIN_WRITES = 6;

    // register sequence of one window setup, entry 0 goes out first
    localparam logic [WIN_WRITES-1:0][7:0] WIN_REGS = {
        REG_RAM_Y, REG_RAM_X, REG_VWIN_END, REG_VWIN_START, REG_HWIN_END, REG_HWIN_START
    };

    // configuration register indexes
    localparam logic CFG_ROTATION = 1'b0;

endpackage
`default_nettype wire

[src/display_rect_clip_rotate_commands.sv]
// rectangle fill and pixel command front end with clipping and screen rotation
//
// Commands enter on the input channel (i_valid / o_ready) and come out as a
// stream of controller words on the output channel (o_valid / i_ready).
// A fill rectangle gives thirteen words: six window setup writes, one pixel
// run carrying the colour and the pixel count, and six writes that restore the
// full screen window. A single pixel gives three words: RAM X, RAM Y and the
// colour written to the GRAM data register. A command that is clipped away, or a
// fill rectangle with a nonpositive size, gives no word at all.
// A command passes the input register and then the result register before its
// first word is offered. Throughput is set by the single output port: one word
// per cycle while the receiver does not stall. A command is registered at the
// input, clipped and mapped in one pass, and its words are held in a result
// register that a counter walks through; the next command waits in the input
// register meanwhile and moves in at the cycle the last word is taken.
// When the receiver stalls, the current word holds and the input register
// fills, after which o_ready drops. Reset empties both stages and sets the
// rotation register (APB byte address 0) to zero.
`default_nettype none
module display_rect_clip_rotate_commands #(
    parameter int PANEL_WIDTH  = 176,
    parameter int PANEL_HEIGHT = 220
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // apb configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // command input
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_opcode,
    input  wire logic [15:0] i_x_pos,
    input  wire logic [15:0] i_y_pos,
    input  wire logic [15:0] i_rect_width,
    input  wire logic [15:0] i_rect_height,
    input  wire logic [15:0] i_color,
    // controller word output
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_kind,
    output logic      [7:0]  o_reg_addr,
    output logic      [15:0] o_reg_data,
    output logic      [15:0] o_run_count,
    output logic             o_last
);
    import drcr_pkg::*;

    localparam int MAXD = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
    localparam int CW   = (MAXD > 1) ? $clog2(MAXD) : 1;
    localparam int PW   = 2 * (CW + 1);
    localparam logic [CW-1:0] WM1 = CW'(PANEL_WIDTH - 1);
    localparam logic [CW-1:0] HM1 = CW'(PANEL_HEIGHT - 1);
    localparam logic [3:0] IDX_RUN       = 4'd6;
    localparam logic [3:0] IDX_FULL      = 4'd7;
    localparam logic [3:0] IDX_RECT_LAST = 4'd12;
    localparam logic [3:0] IDX_PIX_X     = 4'd0;
    localparam logic [3:0] IDX_PIX_Y     = 4'd1;

    typedef logic [WIN_WRITES-1:0][CW-1:0] t_win;

    // map a logical window to panel coordinates in emission order:
    // hstart, hend, vstart, vend, ram x, ram y
    function automatic t_win map_win(input logic [1:0] rot, input logic [CW-1:0] a1,
                                     input logic [CW-1:0] b1, input logic [CW-1:0] a2,
                                     input logic [CW-1:0] b2);
        t_win m;
        case (rot)
            2'd1: begin
                m[0] = WM1 - b2; m[1] = WM1 - b1; m[2] = a1; m[3] = a2;
                m[4] = WM1 - b1; m[5] = a1;
            end
            2'd2: begin
                m[0] = WM1 - a2; m[1] = WM1 - a1; m[2] = HM1 - b2; m[3] = HM1 - b1;
                m[4] = WM1 - a1; m[5] = HM1 - b1;
            end
            2'd3: begin
                m[0] = b1; m[1] = b2; m[2] = HM1 - a2; m[3] = HM1 - a1;
                m[4] = b1; m[5] = HM1 - a1;
            end
            default: begin
                m[0] = a1; m[1] = a2; m[2] = b1; m[3] = b2;
                m[4] = a1; m[5] = b1;
            end
        endcase
        return m;
    endfunction

    // configuration register
    logic [1:0] r_rotation;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_ROTATION);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation <= 2'd0;
        end else if (cfg_wr) begin
            r_rotation <= pwdata[1:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            CFG_ROTATION: prdata = {30'd0, r_rotation};
            default:      prdata = 32'd0;
        endcase
    end

    // input register
    logic        r_in_valid;
    logic        r_in_op;
    logic [15:0] r_in_x, r_in_y, r_in_w, r_in_h, r_in_color;
    logic        in_adv;
    logic        res_free;
    logic        out_last;

    assign o_ready = !r_in_valid || in_adv;
    assign in_adv  = r_in_valid && res_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_op    <= i_opcode;
            r_in_x     <= i_x_pos;
            r_in_y     <= i_y_pos;
            r_in_w     <= i_rect_width;
            r_in_h     <= i_rect_height;
            r_in_color <= i_color;
        end
    end

    // clip against the rotated screen
    logic signed [17:0] xs, ys, ws, hs, x2s, y2s, sw, sh;
    logic signed [17:0] cx1, cy1, cx2, cy2, dws, dhs;
    logic               odd, pix_keep, rect_keep, keep;
    logic [CW-1:0]      sw_m1, sh_m1;
    t_win               n_win, n_full;

    always_comb begin
        odd   = r_rotation[0];
        sw    = odd ? $signed(18'(PANEL_HEIGHT)) : $signed(18'(PANEL_WIDTH));
        sh    = odd ? $signed(18'(PANEL_WIDTH)) : $signed(18'(PANEL_HEIGHT));
        sw_m1 = odd ? HM1 : WM1;
        sh_m1 = odd ? WM1 : HM1;
        xs    = $signed({{2{r_in_x[15]}}, r_in_x});
        ys    = $signed({{2{r_in_y[15]}}, r_in_y});
        ws    = $signed({{2{r_in_w[15]}}, r_in_w});
        hs    = $signed({{2{r_in_h[15]}}, r_in_h});
        x2s   = xs + ws - 18'sd1;
        y2s   = ys + hs - 18'sd1;

        pix_keep  = (xs >= 18'sd0) && (ys >= 18'sd0) && (xs < sw) && (ys < sh);
        rect_keep = (ws > 18'sd0) && (hs > 18'sd0) && (xs < sw) && (ys < sh)
                    && (x2s >= 18'sd0) && (y2s >= 18'sd0);

        cx1 = (xs < 18'sd0) ? 18'sd0 : xs;
        cy1 = (ys < 18'sd0) ? 18'sd0 : ys;
        cx2 = (x2s >= sw) ? sw - 18'sd1 : x2s;
        cy2 = (y2s >= sh) ? sh - 18'sd1 : y2s;
        dws = cx2 - cx1 + 18'sd1;
        dhs = cy2 - cy1 + 18'sd1;

        if (r_in_op == OP_PIXEL) begin
            keep  = pix_keep;
            n_win = map_win(r_rotation, xs[CW-1:0], ys[CW-1:0], xs[CW-1:0], ys[CW-1:0]);
        end else begin
            keep  = rect_keep;
            n_win = map_win(r_rotation, cx1[CW-1:0], cy1[CW-1:0], cx2[CW-1:0], cy2[CW-1:0]);
        end
        n_full = map_win(r_rotation, '0, '0, sw_m1, sh_m1);
    end

    // result register and word counter
    logic          r_res_valid;
    logic          r_mode;
    logic [3:0]    r_idx;
    t_win          r_win, r_full;
    logic [CW:0]   r_dw, r_dh;
    logic [15:0]   r_color;
    logic [PW-1:0] prod;
    logic [3:0]    full_idx;

    assign res_free = !r_res_valid || (i_ready && out_last);
    assign o_valid  = r_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_idx       <= 4'd0;
        end else if (res_free) begin
            r_res_valid <= in_adv && keep;
            r_idx       <= 4'd0;
        end else if (i_ready) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_free && in_adv) begin
            r_mode  <= r_in_op;
            r_win   <= n_win;
            r_full  <= n_full;
            r_dw    <= dws[CW:0];
            r_dh    <= dhs[CW:0];
            r_color <= r_in_color;
        end
    end

    // output word selection
    assign prod     = PW'(r_dw) * PW'(r_dh);
    assign full_idx = r_idx - IDX_FULL;

    always_comb begin
        o_kind      = KIND_REG;
        o_reg_addr  = 8'd0;
        o_reg_data  = 16'd0;
        o_run_count = 16'd0;
        out_last    = 1'b0;
        if (r_mode == OP_PIXEL) begin
            case (r_idx)
                IDX_PIX_X: begin
                    o_reg_addr = REG_RAM_X;
                    o_reg_data = 16'(r_win[4]);
                end
                IDX_PIX_Y: begin
                    o_reg_addr = REG_RAM_Y;
                    o_reg_data = 16'(r_win[5]);
                end
                default: begin
                    o_reg_addr = REG_GRAM;
                    o_reg_data = r_color;
                    out_last   = 1'b1;
                end
            endcase
        end else if (r_idx < IDX_RUN) begin
            o_reg_addr = WIN_REGS[r_idx[2:0]];
            o_reg_data = 16'(r_win[r_idx[2:0]]);
        end else if (r_idx == IDX_RUN) begin
            o_kind      = KIND_RUN;
            o_reg_addr  = REG_GRAM;
            o_reg_data  = r_color;
            o_run_count = 16'(prod);
        end else begin
            o_reg_addr = WIN_REGS[full_idx[2:0]];
            o_reg_data = 16'(r_full[full_idx[2:0]]);
            out_last   = (r_idx == IDX_RECT_LAST);
        end
    end

    assign o_last = out_last;

endmodule
`default_nettype wire
